FILE: design/kmnl_pkg.sv
// Shared types and constants for the key to MIDI note latch.
// No dependencies; every other file of the block refers to it by scoped names.
package kmnl_pkg;

    // Input mode codes
    localparam logic [2:0] MODE_NOTE     = 3'd0;
    localparam logic [2:0] MODE_CAPS     = 3'd1;
    localparam logic [2:0] MODE_OCT_UP   = 3'd2;
    localparam logic [2:0] MODE_OCT_DOWN = 3'd3;
    localparam logic [2:0] MODE_TARGET   = 3'd4;
    localparam logic [2:0] MODE_ENABLE   = 3'd5;
    localparam logic [2:0] MODE_OTHER    = 3'd6;

    // Register indexes
    localparam logic REG_INIT_BASE = 1'b0;
    localparam logic REG_VELOCITY  = 1'b1;

    localparam int RESET_BASE     = 48;
    localparam int RESET_VELOCITY = 100;
    localparam int OCTAVE         = 12;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  semitone;
        logic        pressed;
        logic        released;
        logic        repeat_req;
        logic        modified;
        logic [63:0] unit_id;
        logic        enable_value;
        logic        sink_accepts;
    } t_in;

    typedef struct packed {
        logic        consumed;
        logic        message_valid;
        logic        note_on;
        logic [6:0]  note_number;
        logic [6:0]  velocity;
        logic [63:0] message_unit;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPS,
        OP_TARGET,
        OP_ENABLE,
        OP_OCTAVE,
        OP_RELEASE,
        OP_PRESS
    } t_op;

    // Decoded command handed from front to back
    typedef struct packed {
        t_op         op;
        logic        act;      // press that is not a repeat
        logic        touched;  // press or release
        logic        up;       // octave direction
        logic [4:0]  key;
        logic [63:0] unit;
        logic        want;
        logic        accept;
    } t_cmd;

    // Configuration seen by the back end
    typedef struct packed {
        logic       base_wr;
        logic [6:0] base_val;
        logic [6:0] velocity;
    } t_cfg;

    typedef struct packed {
        logic [63:0] unit;
        logic [6:0]  note;
    } t_latch;

    typedef enum logic [0:0] {
        BS_IDLE,
        BS_SCAN
    } t_bstate;

endpackage

FILE: design/key_to_midi_note_latch_top.sv
// Top level of the key to MIDI note latch: APB register file, front, queue, back.
// Depends on kmnl_pkg, kmnl_front, kmnl_queue and kmnl_back.
//
// Turns keyboard events into MIDI note-on and note-off messages. Each input
// transfer carries one key event and yields one or more result transfers; the
// final one has last set and carries the consumed flag. A note key press sends
// note-on once and latches the key's unit and note; its release sends the
// matching note-off. Disabling, moving the base note by an octave or changing
// the target releases every latched key in ascending key order. A refused
// message (sink_accepts low) leaves the latch as it was. Timing: an event is
// decoded and queued at its input transfer, and the back end takes it from the
// two-entry queue once idle and with its output free; a single-result event
// then goes into the output register. A key release that sends a note-off
// goes through the scan state and the latch read stage before the output
// register. A release-all walks the key latches one key per cycle, while the
// sink keeps up, from the lowest key up to the highest latched key, each
// note-off passing the latch read stage. Registers (APB, 32-bit data): 0x0
// initial base note (also loads the current base note, limited to
// MAX_BASE_NOTE, reset 48), 0x4 press velocity (reset 100). Write registers
// only while the block is idle.
module key_to_midi_note_latch_top #(
    parameter int NUM_KEYS      = 29,
    parameter int MAX_BASE_NOTE = 96
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // event input channel
    input  logic           i_in_valid,
    input  kmnl_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    // result output channel
    output logic           o_out_valid,
    output kmnl_pkg::t_out o_out_data,
    input  logic           i_out_stall,
    // register port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [6:0]     r_init_base;
    logic [6:0]     r_velocity;
    logic           wr_en;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    kmnl_pkg::t_cmd f_cmd;
    kmnl_pkg::t_cmd q_cmd;
    kmnl_pkg::t_cfg cfg;

    // ---- register file ----
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_base <= 7'(kmnl_pkg::RESET_BASE);
            r_velocity  <= 7'(kmnl_pkg::RESET_VELOCITY);
        end else if (wr_en) begin
            unique case (paddr[2])
                kmnl_pkg::REG_INIT_BASE: r_init_base <= pwdata[6:0];
                kmnl_pkg::REG_VELOCITY:  r_velocity  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            kmnl_pkg::REG_INIT_BASE: prdata = {25'd0, r_init_base};
            kmnl_pkg::REG_VELOCITY:  prdata = {25'd0, r_velocity};
            default:                 prdata = 32'd0;
        endcase
    end

    // base note load happens in the back end on the same transfer
    assign cfg.base_wr  = wr_en & (paddr[2] == kmnl_pkg::REG_INIT_BASE);
    assign cfg.base_val = pwdata[6:0];
    assign cfg.velocity = r_velocity;

    // ---- front: classify each event ----
    kmnl_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_item (i_in_data),
        .o_cmd  (f_cmd)
    );

    // stall depends only on queue occupancy, never on valid
    assign o_in_stall = q_full;

    kmnl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid & ~q_full),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // ---- back: state, latches and result generation ----
    kmnl_back #(
        .NUM_KEYS      (NUM_KEYS),
        .MAX_BASE_NOTE (MAX_BASE_NOTE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: design/kmnl_front.sv
// Front end: classifies one key event into a back-end command.
// Depends on kmnl_pkg.
module kmnl_front #(
    parameter int NUM_KEYS = 29
) (
    input  kmnl_pkg::t_in  i_item,
    output kmnl_pkg::t_cmd o_cmd
);

    logic in_range;

    assign in_range = {2'b00, i_item.semitone} < 7'(NUM_KEYS);

    always_comb begin
        o_cmd.op      = kmnl_pkg::OP_NONE;
        o_cmd.act     = i_item.pressed & ~i_item.repeat_req;
        o_cmd.touched = i_item.pressed | i_item.released;
        o_cmd.up      = (i_item.mode == kmnl_pkg::MODE_OCT_UP);
        o_cmd.key     = i_item.semitone;
        o_cmd.unit    = i_item.unit_id;
        o_cmd.want    = i_item.enable_value;
        o_cmd.accept  = i_item.sink_accepts;
        unique case (i_item.mode) inside
            kmnl_pkg::MODE_CAPS:   o_cmd.op = kmnl_pkg::OP_CAPS;
            kmnl_pkg::MODE_TARGET: o_cmd.op = kmnl_pkg::OP_TARGET;
            kmnl_pkg::MODE_ENABLE: o_cmd.op = kmnl_pkg::OP_ENABLE;
            kmnl_pkg::MODE_OCT_UP, kmnl_pkg::MODE_OCT_DOWN: begin
                if (!i_item.modified) begin
                    o_cmd.op = kmnl_pkg::OP_OCTAVE;
                end
            end
            kmnl_pkg::MODE_NOTE: begin
                // release wins over a simultaneous press
                if (!i_item.modified && in_range) begin
                    if (i_item.released) begin
                        o_cmd.op = kmnl_pkg::OP_RELEASE;
                    end else if (i_item.pressed) begin
                        o_cmd.op = kmnl_pkg::OP_PRESS;
                    end
                end
            end
            default: o_cmd.op = kmnl_pkg::OP_NONE;  // other key, unused code
        endcase
    end

endmodule

FILE: design/kmnl_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on kmnl_pkg.
module kmnl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kmnl_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output kmnl_pkg::t_cmd o_data
);

    kmnl_pkg::t_cmd r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

FILE: design/kmnl_back.sv
// Back end: owns enable, base note, target and key latches, and issues results.
// Depends on kmnl_pkg; fed by kmnl_queue.
module kmnl_back #(
    parameter int NUM_KEYS      = 29,
    parameter int MAX_BASE_NOTE = 96
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kmnl_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  kmnl_pkg::t_cmd i_q_data,
    output logic           o_q_pop,
    output logic           o_out_valid,
    output kmnl_pkg::t_out o_out_data,
    input  logic           i_out_stall
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [6:0] BASE_MAX   = 7'(MAX_BASE_NOTE);
    localparam logic [6:0] BASE_RESET = (kmnl_pkg::RESET_BASE > MAX_BASE_NOTE) ?
                                        7'(MAX_BASE_NOTE) : 7'(kmnl_pkg::RESET_BASE);

    kmnl_pkg::t_latch  r_latch_mem [NUM_KEYS];
    kmnl_pkg::t_latch  r_rd;

    kmnl_pkg::t_bstate r_state,   n_state;
    logic              r_enabled, n_enabled;
    logic [6:0]        r_base,    n_base;
    logic [63:0]       r_target,  n_target;
    logic [NUM_KEYS-1:0] r_vbits, n_vbits;
    logic [NUM_KEYS-1:0] r_pend,  n_pend;
    logic [KEY_W-1:0]  r_idx,     n_idx;
    logic              r_consumed, n_consumed;
    logic              r_b_valid, n_b_valid;
    logic              r_b_last,  n_b_last;
    logic              r_out_valid, n_out_valid;
    kmnl_pkg::t_out    r_out,     n_out;

    logic                out_free;
    logic                mem_we;
    logic                mem_re;
    logic [KEY_W-1:0]    key;
    logic [NUM_KEYS-1:0] all_mask;
    logic [NUM_KEYS-1:0] key_bit;
    logic [NUM_KEYS-1:0] pend_left;
    logic [NUM_KEYS-1:0] mask;
    logic [6:0]          note;
    logic [7:0]          up_sum;
    logic [6:0]          next_base;
    logic                cons;
    logic                emit_on;

    assign key       = KEY_W'(i_q_data.key);
    assign key_bit   = NUM_KEYS'(1) << key;
    assign all_mask  = i_q_data.accept ? r_vbits : '0;
    assign note      = 7'(r_base + 7'(i_q_data.key));
    assign up_sum    = {1'b0, r_base} + 8'(kmnl_pkg::OCTAVE);
    assign pend_left = r_pend & ~(NUM_KEYS'(1) << r_idx);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        if (i_q_data.up) begin
            next_base = (up_sum > {1'b0, BASE_MAX}) ? BASE_MAX : up_sum[6:0];
        end else begin
            next_base = (r_base < 7'(kmnl_pkg::OCTAVE)) ? 7'd0 :
                        r_base - 7'(kmnl_pkg::OCTAVE);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_enabled   = r_enabled;
        n_base      = r_base;
        n_target    = r_target;
        n_vbits     = r_vbits;
        n_pend      = r_pend;
        n_idx       = r_idx;
        n_consumed  = r_consumed;
        n_b_valid   = r_b_valid;
        n_b_last    = r_b_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mask        = '0;
        cons        = 1'b0;
        emit_on     = 1'b0;

        if (out_free) begin
            n_out_valid = 1'b0;
        end

        // note-off from the latch read stage
        if (r_b_valid && out_free) begin
            n_out_valid = 1'b1;
            n_out       = '{consumed: r_b_last & r_consumed, message_valid: 1'b1,
                            note_on: 1'b0, note_number: r_rd.note, velocity: 7'd0,
                            message_unit: r_rd.unit, last: r_b_last};
            n_b_valid   = 1'b0;
        end

        unique case (r_state)
            kmnl_pkg::BS_SCAN: begin
                if (!r_b_valid || out_free) begin
                    if (r_pend[r_idx]) begin
                        mem_re         = 1'b1;
                        n_b_valid      = 1'b1;
                        n_b_last       = (pend_left == '0);
                        n_vbits[r_idx] = 1'b0;
                    end
                    n_pend = pend_left;
                    n_idx  = r_idx + KEY_W'(1);
                    if (pend_left == '0) begin
                        n_state = kmnl_pkg::BS_IDLE;
                    end
                end
            end
            kmnl_pkg::BS_IDLE: begin
                if (i_q_valid && !r_b_valid && out_free) begin
                    o_q_pop = 1'b1;
                    n_idx   = '0;
                    unique case (i_q_data.op)
                        kmnl_pkg::OP_CAPS: begin
                            cons = i_q_data.touched;
                            if (i_q_data.act) begin
                                if (r_enabled) begin
                                    mask = all_mask;
                                end
                                n_enabled = ~r_enabled;
                            end
                        end
                        kmnl_pkg::OP_TARGET: begin
                            if (i_q_data.unit != r_target) begin
                                mask     = all_mask;
                                n_target = i_q_data.unit;
                            end
                        end
                        kmnl_pkg::OP_ENABLE: begin
                            if (i_q_data.want != r_enabled) begin
                                if (!i_q_data.want) begin
                                    mask = all_mask;
                                end
                                n_enabled = i_q_data.want;
                            end
                        end
                        kmnl_pkg::OP_OCTAVE: begin
                            if (r_enabled) begin
                                cons = i_q_data.touched;
                                if (i_q_data.act && next_base != r_base) begin
                                    mask   = all_mask;
                                    n_base = next_base;
                                end
                            end
                        end
                        kmnl_pkg::OP_RELEASE: begin
                            if (r_enabled) begin
                                cons  = 1'b1;
                                mask  = all_mask & key_bit;
                                n_idx = key;
                            end
                        end
                        kmnl_pkg::OP_PRESS: begin
                            if (r_enabled) begin
                                cons = 1'b1;
                                if (i_q_data.act && !r_vbits[key] && r_target != '0 &&
                                    i_q_data.accept) begin
                                    emit_on      = 1'b1;
                                    mem_we       = 1'b1;
                                    n_vbits[key] = 1'b1;
                                end
                            end
                        end
                        default: cons = 1'b0;
                    endcase

                    if (mask != '0) begin
                        n_state    = kmnl_pkg::BS_SCAN;
                        n_pend     = mask;
                        n_consumed = cons;
                    end else begin
                        n_out_valid = 1'b1;
                        if (emit_on) begin
                            n_out = '{consumed: cons, message_valid: 1'b1, note_on: 1'b1,
                                      note_number: note, velocity: i_cfg.velocity,
                                      message_unit: r_target, last: 1'b1};
                        end else begin
                            n_out = '{consumed: cons, message_valid: 1'b0, note_on: 1'b0,
                                      note_number: 7'd0, velocity: 7'd0,
                                      message_unit: 64'd0, last: 1'b1};
                        end
                    end
                end
            end
            default: n_state = kmnl_pkg::BS_IDLE;
        endcase

        // base note register write, to be done only while idle; the block does not enforce it
        if (i_cfg.base_wr) begin
            n_base = (i_cfg.base_val > BASE_MAX) ? BASE_MAX : i_cfg.base_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kmnl_pkg::BS_IDLE;
            r_enabled   <= 1'b0;
            r_base      <= BASE_RESET;
            r_target    <= '0;
            r_vbits     <= '0;
            r_pend      <= '0;
            r_idx       <= '0;
            r_consumed  <= 1'b0;
            r_b_valid   <= 1'b0;
            r_b_last    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enabled   <= n_enabled;
            r_base      <= n_base;
            r_target    <= n_target;
            r_vbits     <= n_vbits;
            r_pend      <= n_pend;
            r_idx       <= n_idx;
            r_consumed  <= n_consumed;
            r_b_valid   <= n_b_valid;
            r_b_last    <= n_b_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // latch memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_latch_mem[key] <= '{unit: r_target, note: note};
        end
        if (mem_re) begin
            r_rd <= r_latch_mem[r_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for key_to_midi_note_latch_top: a directed key sequence, then
// random key events under varied idling, checked by a scoreboard. Depends on kmnl_pkg.
module tb;

    localparam int         NUM_KEYS    = 29;
    localparam int         MAX_BASE    = 96;
    localparam logic [2:0] MODE_UNUSED = 3'd7;   // not decoded, acts as other key

    // Mirror of the block: holds its note state and the expected output transfers.
    class midi_msg_scoreboard;
        bit              enabled;
        bit [6:0]        base_note;
        bit [6:0]        velocity;
        bit [63:0]       target_unit;
        bit              held[NUM_KEYS];
        bit [63:0]       held_unit[NUM_KEYS];
        bit [6:0]        held_note[NUM_KEYS];
        kmnl_pkg::t_out  batch[$];
        kmnl_pkg::t_out  expected_msgs[$];
        int              fail_count;

        function new();
            enabled     = 0;
            base_note   = 7'(kmnl_pkg::RESET_BASE);
            velocity    = 7'(kmnl_pkg::RESET_VELOCITY);
            target_unit = '0;
            fail_count  = 0;
            foreach (held[i]) held[i] = 0;
        endfunction

        function void write_reg(logic idx, bit [6:0] val);
            if (idx == kmnl_pkg::REG_INIT_BASE)
                base_note = (val > MAX_BASE) ? 7'(MAX_BASE) : val;
            else
                velocity = val;
        endfunction

        function void push_msg(bit on, bit [6:0] note, bit [6:0] vel, bit [63:0] unit);
            kmnl_pkg::t_out m;
            m = '0;
            m.message_valid = 1;
            m.note_on       = on;
            m.note_number   = note;
            m.velocity      = vel;
            m.message_unit  = unit;
            batch.push_back(m);
        endfunction

        // Note-off for every held key, lowest key first; refused ones stay held.
        function void release_held(bit accept);
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (held[i] && accept && held_unit[i] != 0) begin
                    push_msg(0, held_note[i], 7'd0, held_unit[i]);
                    held[i] = 0;
                end
            end
        endfunction

        function void predict_event(kmnl_pkg::t_in ev);
            bit             consumed;
            bit             touched;
            int             next;
            int             k;
            bit [7:0]       sum;
            kmnl_pkg::t_out tail;
            batch.delete();
            consumed = 0;
            touched  = ev.pressed | ev.released;
            k        = int'(ev.semitone);
            case (ev.mode)
                kmnl_pkg::MODE_CAPS: begin
                    if (ev.pressed && !ev.repeat_req) begin
                        if (enabled) release_held(ev.sink_accepts);
                        enabled = !enabled;
                    end
                    consumed = touched;
                end
                kmnl_pkg::MODE_TARGET: begin
                    if (ev.unit_id != target_unit) begin
                        release_held(ev.sink_accepts);
                        target_unit = ev.unit_id;
                    end
                end
                kmnl_pkg::MODE_ENABLE: begin
                    if (ev.enable_value != enabled) begin
                        if (!ev.enable_value) release_held(ev.sink_accepts);
                        enabled = ev.enable_value;
                    end
                end
                default: begin
                    if (!enabled || ev.modified) begin
                        consumed = 0;
                    end else if (ev.mode == kmnl_pkg::MODE_OCT_UP ||
                                 ev.mode == kmnl_pkg::MODE_OCT_DOWN) begin
                        if (ev.pressed && !ev.repeat_req) begin
                            if (ev.mode == kmnl_pkg::MODE_OCT_UP)
                                next = (base_note + kmnl_pkg::OCTAVE > MAX_BASE) ?
                                       MAX_BASE : base_note + kmnl_pkg::OCTAVE;
                            else
                                next = (base_note < kmnl_pkg::OCTAVE) ?
                                       0 : base_note - kmnl_pkg::OCTAVE;
                            if (next != base_note) begin
                                release_held(ev.sink_accepts);
                                base_note = 7'(next);
                            end
                        end
                        consumed = touched;
                    end else if (ev.mode == kmnl_pkg::MODE_NOTE && k < NUM_KEYS) begin
                        consumed = 1;
                        if (ev.released) begin
                            if (held[k] && ev.sink_accepts && held_unit[k] != 0) begin
                                push_msg(0, held_note[k], 7'd0, held_unit[k]);
                                held[k] = 0;
                            end
                        end else if (ev.pressed) begin
                            if (!ev.repeat_req && !held[k] && target_unit != 0 &&
                                ev.sink_accepts) begin
                                sum = base_note + ev.semitone;
                                push_msg(1, sum[6:0], velocity, target_unit);
                                held[k]      = 1;
                                held_unit[k] = target_unit;
                                held_note[k] = sum[6:0];
                            end
                        end else begin
                            consumed = 0;
                        end
                    end
                end
            endcase
            if (batch.size() == 0) begin
                tail = '0;
            end else begin
                tail = batch.pop_back();
            end
            tail.consumed = consumed;
            tail.last     = 1;
            batch.push_back(tail);
            foreach (batch[i]) expected_msgs.push_back(batch[i]);
        endfunction

        function void check_msg(kmnl_pkg::t_out got);
            kmnl_pkg::t_out exp;
            if (expected_msgs.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result transfer: %p", got);
                return;
            end
            exp = expected_msgs.pop_front();
            if (got.consumed !== exp.consumed || got.message_valid !== exp.message_valid ||
                got.note_on !== exp.note_on || got.note_number !== exp.note_number ||
                got.velocity !== exp.velocity || got.message_unit !== exp.message_unit ||
                got.last !== exp.last) begin
                fail_count++;
                if (fail_count <= 10) $display("result mismatch: expected %p, got %p", exp, got);
            end
        endfunction
    endclass

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           i_in_valid = 1'b0;
    kmnl_pkg::t_in  i_in_data  = '0;
    logic           o_in_stall;
    logic           o_out_valid;
    kmnl_pkg::t_out o_out_data;
    logic           i_out_stall = 1'b1;
    logic           psel    = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite  = 1'b0;
    logic [2:0]     paddr   = '0;
    logic [31:0]    pwdata  = '0;
    logic [31:0]    prdata;
    logic           pready;

    midi_msg_scoreboard sb = new();
    int send_idle_pct = 0;   // chance the sender idles before a transfer
    int out_stall_pct = 0;   // chance the receiver stalls in a cycle

    key_to_midi_note_latch_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // Receiver side: random stall, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Both channels are sampled at the edge; inputs feed the predictor first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.predict_event(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_msg(o_out_data);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic kmnl_pkg::t_in key_event(logic [2:0] mode, logic [4:0] semi, bit pr,
                                                bit rl, bit rp, bit md, logic [63:0] unit,
                                                bit want, bit acc);
        kmnl_pkg::t_in e;
        e.mode         = mode;
        e.semitone     = semi;
        e.pressed      = pr;
        e.released     = rl;
        e.repeat_req   = rp;
        e.modified     = md;
        e.unit_id      = unit;
        e.enable_value = want;
        e.sink_accepts = acc;
        return e;
    endfunction

    // Mostly note keys on a few low keys, so presses and releases meet the latches.
    function automatic kmnl_pkg::t_in random_event();
        kmnl_pkg::t_in e;
        int            r;
        int            f;
        e.unit_id      = {$urandom, $urandom};
        e.enable_value = ($urandom_range(99) < 80);
        e.sink_accepts = ($urandom_range(99) < 88);
        e.repeat_req   = ($urandom_range(9) == 0);
        e.modified     = ($urandom_range(11) == 0);
        f = $urandom_range(99);
        e.pressed  = (f < 50) || (f >= 88 && f < 93);
        e.released = (f >= 50 && f < 93);
        e.semitone = ($urandom_range(99) < 70) ? 5'($urandom_range(7))
                                               : 5'($urandom_range(31));
        r = $urandom_range(99);
        if      (r < 50) e.mode = kmnl_pkg::MODE_NOTE;
        else if (r < 55) e.mode = kmnl_pkg::MODE_CAPS;
        else if (r < 63) e.mode = kmnl_pkg::MODE_OCT_UP;
        else if (r < 71) e.mode = kmnl_pkg::MODE_OCT_DOWN;
        else if (r < 78) e.mode = kmnl_pkg::MODE_TARGET;
        else if (r < 87) e.mode = kmnl_pkg::MODE_ENABLE;
        else if (r < 97) e.mode = kmnl_pkg::MODE_OTHER;
        else             e.mode = MODE_UNUSED;
        if (e.mode == kmnl_pkg::MODE_TARGET) begin
            r = $urandom_range(99);
            if      (r < 10) e.unit_id = '0;
            else if (r < 20) e.unit_id = '1;
            else if (r < 60) e.unit_id = 64'($urandom_range(3, 1));
        end
        return e;
    endfunction

    // One input transfer; valid stays up straight into the next one unless the sender idles.
    task automatic send_event(kmnl_pkg::t_in ev);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Wait for every expected result, then let a full release-all scan die out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_msgs.size() != 0) @(posedge i_clk);
        repeat (NUM_KEYS + 12) @(posedge i_clk);
    endtask

    task automatic reg_write(logic idx, bit [6:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {25'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        out_stall_pct = stall;
        // Enable and aim at a unit first so most of the phase reaches the latches.
        send_event(key_event(kmnl_pkg::MODE_ENABLE, 0, 0, 0, 0, 0, '0, 1, 1));
        send_event(key_event(kmnl_pkg::MODE_TARGET, 0, 0, 0, 0, 0,
                             64'($urandom_range(3, 1)), 1, 1));
        repeat (n) send_event(random_event());
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sequence, reset registers: base note 48, velocity 100.
        send_event(key_event(kmnl_pkg::MODE_NOTE,   0, 1, 0, 0, 0, '0, 0, 1)); // disabled
        send_event(key_event(kmnl_pkg::MODE_CAPS,   0, 1, 0, 0, 0, '0, 0, 1)); // enable
        send_event(key_event(kmnl_pkg::MODE_NOTE,   3, 1, 0, 0, 0, '0, 0, 1)); // no target
        send_event(key_event(kmnl_pkg::MODE_TARGET, 0, 0, 0, 0, 0, '1, 0, 1));
        send_event(key_event(kmnl_pkg::MODE_NOTE,   0, 1, 0, 0, 0, '0, 0, 1)); // lowest key
        send_event(key_event(kmnl_pkg::MODE_NOTE,  28, 1, 0, 0, 0, '0, 0, 1)); // highest key
        send_event(key_event(kmnl_pkg::MODE_NOTE,  28, 1, 0, 0, 0, '0, 0, 1)); // already held
        send_event(key_event(kmnl_pkg::MODE_NOTE,   5, 1, 0, 1, 0, '0, 0, 1)); // auto-repeat
        send_event(key_event(kmnl_pkg::MODE_NOTE,  31, 1, 0, 0, 0, '0, 0, 1)); // out of range
        send_event(key_event(kmnl_pkg::MODE_NOTE,   3, 1, 0, 0, 1, '0, 0, 1)); // modifier
        send_event(key_event(kmnl_pkg::MODE_NOTE,   7, 1, 0, 0, 0, '0, 0, 0)); // sink refuses
        // press with release on the same key
        send_event(key_event(kmnl_pkg::MODE_NOTE,   0, 1, 1, 0, 0, '0, 0, 1));
        send_event(key_event(kmnl_pkg::MODE_NOTE,   1, 0, 0, 0, 0, '0, 0, 1)); // no flag
        send_event(key_event(kmnl_pkg::MODE_NOTE,  10, 1, 0, 0, 0, '0, 0, 1));
        // repeat does not shift, then a release only
        send_event(key_event(kmnl_pkg::MODE_OCT_UP, 0, 1, 0, 1, 0, '0, 0, 1));
        send_event(key_event(kmnl_pkg::MODE_OCT_UP, 0, 0, 1, 0, 0, '0, 0, 1));
        // Up to the ceiling and once more against it; first step releases keys 10, 28.
        repeat (5) send_event(key_event(kmnl_pkg::MODE_OCT_UP, 0, 1, 0, 0, 0, '0, 0, 1));
        send_event(key_event(kmnl_pkg::MODE_NOTE,  28, 1, 0, 0, 0, '0, 0, 1)); // top note
        send_event(key_event(kmnl_pkg::MODE_TARGET, 0, 0, 0, 0, 0, 64'd1, 0, 1));
        send_event(key_event(kmnl_pkg::MODE_NOTE,   2, 1, 0, 0, 0, '0, 0, 1));
        // note-off refused, so the old note stays held for the release after it
        send_event(key_event(kmnl_pkg::MODE_OCT_DOWN, 0, 1, 0, 0, 0, '0, 0, 0));
        send_event(key_event(kmnl_pkg::MODE_NOTE,   2, 0, 1, 0, 0, '0, 0, 1));
        send_event(key_event(kmnl_pkg::MODE_NOTE,   4, 1, 0, 0, 0, '0, 0, 1));
        send_event(key_event(kmnl_pkg::MODE_CAPS,   0, 1, 0, 0, 0, '0, 0, 1)); // disable
        send_event(key_event(kmnl_pkg::MODE_CAPS,   0, 1, 0, 1, 0, '0, 0, 1)); // repeat
        send_event(key_event(kmnl_pkg::MODE_CAPS,   0, 0, 1, 0, 0, '0, 0, 1)); // release
        send_event(key_event(kmnl_pkg::MODE_ENABLE, 0, 0, 0, 0, 0, '0, 0, 1)); // unchanged
        send_event(key_event(kmnl_pkg::MODE_OTHER,  0, 1, 0, 0, 0, '0, 0, 1)); // disabled
        send_event(key_event(MODE_UNUSED,           0, 1, 0, 0, 0, '0, 1, 1));
        send_event(key_event(kmnl_pkg::MODE_ENABLE, 0, 0, 0, 0, 0, '0, 1, 1));
        send_event(key_event(kmnl_pkg::MODE_NOTE,   9, 1, 0, 0, 0, '0, 0, 1));
        send_event(key_event(kmnl_pkg::MODE_TARGET, 0, 0, 0, 0, 0, '0, 0, 1)); // clear
        send_event(key_event(kmnl_pkg::MODE_OTHER,  0, 1, 0, 0, 0, '0, 0, 1));
        drain();

        // Random phases, each under different register settings and idling.
        reg_write(kmnl_pkg::REG_INIT_BASE, 7'd0);
        reg_write(kmnl_pkg::REG_VELOCITY, 7'd1);
        random_phase(80, 0, 0);
        reg_write(kmnl_pkg::REG_INIT_BASE, 7'd96);
        reg_write(kmnl_pkg::REG_VELOCITY, 7'd127);
        random_phase(80, 86, 0);
        reg_write(kmnl_pkg::REG_INIT_BASE, 7'd120);   // above the ceiling, gets limited
        reg_write(kmnl_pkg::REG_VELOCITY, 7'($urandom_range(127, 1)));
        random_phase(80, 0, 86);
        reg_write(kmnl_pkg::REG_INIT_BASE, 7'($urandom_range(96)));
        reg_write(kmnl_pkg::REG_VELOCITY, 7'd100);
        random_phase(80, 13, 13);

        if (sb.fail_count == 0 && sb.expected_msgs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
